/* rtl/core/avcc2ab_pkg.sv */
// Shared types and constants for the avcC to Annex B converter.
package avcc2ab_pkg;

  localparam int CNT_W = 23;
  localparam int SUM_W = ((CNT_W > 16) ? CNT_W : 16) + 2;
  localparam int CAP_MIN = 128;
  localparam int CAP_DEFAULT = 1024;

  typedef enum logic [3:0] {
    PH_VER    = 4'd0,
    PH_PROF   = 4'd1,
    PH_COMPAT = 4'd2,
    PH_LEVEL  = 4'd3,
    PH_LENSZ  = 4'd4,
    PH_SPSCNT = 4'd5,
    PH_SPSHI  = 4'd6,
    PH_SPSLO  = 4'd7,
    PH_SPSDAT = 4'd8,
    PH_PPSCNT = 4'd9,
    PH_PPSHI  = 4'd10,
    PH_PPSLO  = 4'd11,
    PH_PPSDAT = 4'd12,
    PH_DONE   = 4'd13,
    PH_ERR    = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_VERSION = 3'd1,
    ST_PROFILE = 3'd2,
    ST_LENSIZE = 3'd3,
    ST_NO_SPS  = 3'd4,
    ST_NO_PPS  = 3'd5,
    ST_TRUNC   = 3'd6
  } status_t;

  typedef struct packed {
    logic             start_code;
    logic             data_valid;
    logic [7:0]       data_byte;
    logic             stat_valid;
    status_t          status;
    logic [7:0]       profile;
    logic [7:0]       level;
    logic [2:0]       nal_length_size;
    logic [CNT_W-1:0] total_bytes;
  } res_t;

endpackage

/* rtl/core/avcc2ab_if.sv */
// Stream interfaces for record bytes in and Annex B results out.
interface avcc2ab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_record;

  modport source (output valid, output in_byte, output end_of_record, input ready);
  modport sink (input valid, input in_byte, input end_of_record, output ready);
endinterface

interface avcc2ab_out_if;
  import avcc2ab_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             is_status;
  logic [2:0]       status;
  logic [7:0]       profile;
  logic [7:0]       level;
  logic [2:0]       nal_length_size;
  logic [CNT_W-1:0] total_bytes;
  logic             last;

  modport source (output valid, output out_byte, output is_status, output status,
                  output profile, output level, output nal_length_size,
                  output total_bytes, output last, input ready);
  modport sink (input valid, input out_byte, input is_status, input status,
                input profile, input level, input nal_length_size,
                input total_bytes, input last, output ready);
endinterface

/* rtl/core/avcc_to_annexb_converter_top.sv */
// Top level of the avcC to Annex B converter: config register, result staging, output.
// Takes an H.264 decoder configuration record one byte per transaction and returns
// the SPS and PPS sets as an Annex B stream, each set behind a 00 00 01 start code,
// followed on the final byte by one status transaction (status, profile, level,
// NAL length size and byte count; on a nonzero status the consumer discards the data
// of that record). The input takes one byte per cycle as long as the output side
// keeps up; the output moves one result per cycle while out_ch.ready is high. A
// byte that opens a set yields three results, a data byte one, and the final byte
// one more for the status. Parsing is done as the byte is accepted; a pending stage
// behind the output register lets the next byte in while the current results drain.
// Capacity comes from max_output_bytes at address 0; 128 or less selects 1024 bytes.
module avcc_to_annexb_converter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  avcc2ab_in_if.sink                    in_ch,
  avcc2ab_out_if.source                 out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import avcc2ab_pkg::*;

  logic [CNT_W-1:0] cap_r;
  res_t             res;
  logic             has_res;
  logic             in_acc;

  res_t             a_r;
  logic             a_valid_r;
  logic             a_move;

  res_t             b_r;
  logic [1:0]       b_rem_r;
  logic             b_stat_r;
  logic             b_busy;
  logic             b_finish;
  logic             out_last;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      cap_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  avcc2ab_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (in_acc),
    .in_byte          (in_ch.in_byte),
    .end_of_record    (in_ch.end_of_record),
    .max_output_bytes (cap_r),
    .res              (res)
  );

  assign has_res  = res.start_code | res.data_valid | res.stat_valid;
  assign b_busy   = (b_rem_r != 2'd0) || b_stat_r;
  assign out_last = b_stat_r ? (b_rem_r == 2'd0) : (b_rem_r == 2'd1);
  assign b_finish = b_busy && out_ch.ready && out_last;
  assign a_move   = a_valid_r && (!b_busy || b_finish);
  assign in_ch.ready = !a_valid_r || a_move;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc && has_res) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_res) begin
      a_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_rem_r  <= '0;
      b_stat_r <= 1'b0;
    end else if (a_move) begin
      b_rem_r  <= a_r.start_code ? 2'd3 : (a_r.data_valid ? 2'd1 : 2'd0);
      b_stat_r <= a_r.stat_valid;
    end else if (b_busy && out_ch.ready) begin
      if (b_rem_r != 2'd0) begin
        b_rem_r <= b_rem_r - 2'd1;
      end else begin
        b_stat_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_r <= a_r;
    end
  end

  always_comb begin
    out_ch.valid           = b_busy;
    out_ch.last            = out_last;
    out_ch.out_byte        = '0;
    out_ch.is_status       = 1'b0;
    out_ch.status          = ST_OK;
    out_ch.profile         = '0;
    out_ch.level           = '0;
    out_ch.nal_length_size = '0;
    out_ch.total_bytes     = '0;
    if (b_rem_r != 2'd0) begin
      if (b_r.start_code) begin
        out_ch.out_byte = (b_rem_r == 2'd1) ? 8'h01 : 8'h00;
      end else begin
        out_ch.out_byte = b_r.data_byte;
      end
    end else begin
      out_ch.is_status       = 1'b1;
      out_ch.status          = b_r.status;
      out_ch.profile         = b_r.profile;
      out_ch.level           = b_r.level;
      out_ch.nal_length_size = b_r.nal_length_size;
      out_ch.total_bytes     = b_r.total_bytes;
    end
  end

endmodule

/* rtl/core/avcc2ab_parser.sv */
// Record parser: header checks, SPS/PPS walk, capacity check and status.
module avcc2ab_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [7:0]                     in_byte,
  input  logic                           end_of_record,
  input  logic [avcc2ab_pkg::CNT_W-1:0]  max_output_bytes,
  output avcc2ab_pkg::res_t              res
);
  import avcc2ab_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [4:0]       sets_r, sets_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic [7:0]       prof_r, prof_nxt;
  logic [7:0]       lvl_r, lvl_nxt;
  logic [2:0]       nls_r, nls_nxt;
  status_t          err_r, err_nxt;
  logic             drop_r, drop_nxt;

  logic [15:0]      len;
  logic [CNT_W-1:0] cap;
  logic             over;
  logic             drop_now;
  logic             sps;
  logic [4:0]       sets_dec;
  logic [2:0]       lsz;

  assign len = {hi_r, in_byte};
  assign cap = (max_output_bytes > CNT_W'(CAP_MIN)) ? max_output_bytes : CNT_W'(CAP_DEFAULT);
  assign over = (SUM_W'(emit_r) + SUM_W'(len) + SUM_W'(3)) > SUM_W'(cap);
  assign sps = (phase_r == PH_SPSLO) || (phase_r == PH_SPSDAT);
  assign sets_dec = sets_r - 5'd1;
  assign lsz = {1'b0, in_byte[1:0]} + 3'd1;

  always_comb begin
    phase_nxt = phase_r;
    sets_nxt  = sets_r;
    left_nxt  = left_r;
    hi_nxt    = hi_r;
    emit_nxt  = emit_r;
    prof_nxt  = prof_r;
    lvl_nxt   = lvl_r;
    nls_nxt   = nls_r;
    err_nxt   = err_r;
    drop_nxt  = drop_r;
    drop_now  = drop_r | over;
    res = '0;
    res.data_byte = in_byte;

    unique case (phase_r) inside
      PH_VER: begin
        if (in_byte > 8'd1) begin
          err_nxt   = ST_VERSION;
          phase_nxt = PH_ERR;
        end else begin
          phase_nxt = PH_PROF;
        end
      end
      PH_PROF: begin
        prof_nxt = in_byte;
        if (in_byte == 8'd0) begin
          err_nxt   = ST_PROFILE;
          phase_nxt = PH_ERR;
        end else begin
          phase_nxt = PH_COMPAT;
        end
      end
      PH_COMPAT: begin
        phase_nxt = PH_LEVEL;
      end
      PH_LEVEL: begin
        lvl_nxt   = in_byte;
        phase_nxt = PH_LENSZ;
      end
      PH_LENSZ: begin
        if (lsz < 3'd2) begin
          err_nxt   = ST_LENSIZE;
          phase_nxt = PH_ERR;
        end else begin
          nls_nxt   = lsz;
          phase_nxt = PH_SPSCNT;
        end
      end
      PH_SPSCNT, PH_PPSCNT: begin
        if (in_byte[4:0] == 5'd0) begin
          err_nxt   = (phase_r == PH_SPSCNT) ? ST_NO_SPS : ST_NO_PPS;
          phase_nxt = PH_ERR;
        end else begin
          sets_nxt  = in_byte[4:0];
          drop_nxt  = 1'b0;
          phase_nxt = (phase_r == PH_SPSCNT) ? PH_SPSHI : PH_PPSHI;
        end
      end
      PH_SPSHI, PH_PPSHI: begin
        hi_nxt    = in_byte;
        phase_nxt = (phase_r == PH_SPSHI) ? PH_SPSLO : PH_PPSLO;
      end
      PH_SPSLO, PH_PPSLO: begin
        if (len == 16'd0) begin
          sets_nxt = sets_dec;
          if (sets_dec == 5'd0) begin
            phase_nxt = sps ? PH_PPSCNT : PH_DONE;
          end else begin
            phase_nxt = sps ? PH_SPSHI : PH_PPSHI;
          end
        end else begin
          drop_nxt = drop_now;
          if (!drop_now) begin
            res.start_code = 1'b1;
            emit_nxt = emit_r + CNT_W'(3);
          end
          left_nxt  = len;
          phase_nxt = sps ? PH_SPSDAT : PH_PPSDAT;
        end
      end
      PH_SPSDAT, PH_PPSDAT: begin
        if (!drop_r) begin
          res.data_valid = 1'b1;
          emit_nxt = emit_r + CNT_W'(1);
        end
        left_nxt = left_r - 16'd1;
        if (left_r == 16'd1) begin
          sets_nxt = sets_dec;
          if (sets_dec == 5'd0) begin
            phase_nxt = sps ? PH_PPSCNT : PH_DONE;
          end else begin
            phase_nxt = sps ? PH_SPSHI : PH_PPSHI;
          end
        end
      end
      default: begin
      end
    endcase

    if (end_of_record) begin
      res.stat_valid = 1'b1;
      res.status = err_nxt;
      if (err_nxt == ST_OK && phase_nxt != PH_DONE) begin
        res.status = ST_TRUNC;
      end
      res.profile = prof_nxt;
      res.level = lvl_nxt;
      res.nal_length_size = nls_nxt;
      res.total_bytes = (res.status == ST_OK) ? emit_nxt : '0;
      phase_nxt = PH_VER;
      sets_nxt  = '0;
      left_nxt  = '0;
      hi_nxt    = '0;
      emit_nxt  = '0;
      prof_nxt  = '0;
      lvl_nxt   = '0;
      nls_nxt   = '0;
      err_nxt   = ST_OK;
      drop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VER;
      sets_r  <= '0;
      left_r  <= '0;
      hi_r    <= '0;
      emit_r  <= '0;
      prof_r  <= '0;
      lvl_r   <= '0;
      nls_r   <= '0;
      err_r   <= ST_OK;
      drop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      sets_r  <= sets_nxt;
      left_r  <= left_nxt;
      hi_r    <= hi_nxt;
      emit_r  <= emit_nxt;
      prof_r  <= prof_nxt;
      lvl_r   <= lvl_nxt;
      nls_r   <= nls_nxt;
      err_r   <= err_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule
